[design/e2q_pkg.sv]
// Shared constants, types and functions for the Euler-to-quaternion core.
package e2q_pkg;

	// Number of CORDIC micro-rotations (capped at the atan table length).
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

	// CORDIC datapath width: Q2.30 plus headroom for gain growth and sign.
	localparam int CW = 34;

	localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'sd652032874);
	localparam logic signed [CW-1:0] PI_Q30      = CW'(64'sd3373259426);
	localparam logic signed [CW-1:0] HALF_PI_Q30 = CW'(64'sd1686629713);

	// atan(2^-i) in Q2.30, truncated.
	function automatic logic signed [CW-1:0] atan_q30(input int idx);
		logic [31:0] v;
		begin
			case (idx)
				0:  v = 32'h3243F6A8;
				1:  v = 32'h1DAC6705;
				2:  v = 32'h0FADBAFC;
				3:  v = 32'h07F56EA6;
				4:  v = 32'h03FEAB76;
				5:  v = 32'h01FFD55B;
				6:  v = 32'h00FFFAAA;
				7:  v = 32'h007FFF55;
				8:  v = 32'h003FFFEA;
				9:  v = 32'h001FFFFD;
				10: v = 32'h000FFFFF;
				11: v = 32'h0007FFFF;
				12: v = 32'h0003FFFF;
				13: v = 32'h0001FFFF;
				14: v = 32'h0000FFFF;
				15: v = 32'h00007FFF;
				16: v = 32'h00003FFF;
				17: v = 32'h00001FFF;
				18: v = 32'h00000FFF;
				19: v = 32'h000007FF;
				20: v = 32'h000003FF;
				21: v = 32'h000001FF;
				22: v = 32'h000000FF;
				23: v = 32'h0000007F;
				default: v = 32'h0;
			endcase
			return $signed({{(CW-32){1'b0}}, v});
		end
	endfunction

	// One CORDIC lane state.
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
	} cordic_t;

	// Sine/cosine pair in Q1.14.
	typedef struct packed {
		logic signed [15:0] s;
		logic signed [15:0] c;
	} sincos_t;

endpackage

[design/e2q_cordic.sv]
// Pipelined rotation-mode CORDIC: angle in Q3.12 to sine/cosine of its half-angle in Q1.14.
module e2q_cordic
	import e2q_pkg::*;
(
	input  logic               clk,
	input  logic               adv,
	input  logic signed [15:0] angle,
	output sincos_t            sc
);

	cordic_t st_s [0:NSTEPS];
	cordic_t pre;
	logic signed [CW-1:0] z0;

	// Halve angle (floor), widen to Q2.30, fold into +-pi/2
	always_comb begin
		z0 = CW'(angle >>> 1) <<< 18;
		pre.x = GAIN_Q30;
		pre.y = '0;
		pre.flip = 1'b0;
		pre.z = z0;
		if (z0 > HALF_PI_Q30) begin
			pre.z = z0 - PI_Q30;
			pre.flip = 1'b1;
		end else if (z0 < -HALF_PI_Q30) begin
			pre.z = z0 + PI_Q30;
			pre.flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) st_s[0] <= pre;
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < NSTEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[i+1].flip <= st_s[i].flip;
				if (!st_s[i].z[CW-1]) begin
					st_s[i+1].x <= st_s[i].x - (st_s[i].y >>> i);
					st_s[i+1].y <= st_s[i].y + (st_s[i].x >>> i);
					st_s[i+1].z <= st_s[i].z - atan_q30(i);
				end else begin
					st_s[i+1].x <= st_s[i].x + (st_s[i].y >>> i);
					st_s[i+1].y <= st_s[i].y - (st_s[i].x >>> i);
					st_s[i+1].z <= st_s[i].z + atan_q30(i);
				end
			end
		end
	end

	// Sign fix and round to Q1.14
	logic signed [CW-1:0] xf, yf, xr, yr;
	always_comb begin
		xf = st_s[NSTEPS].flip ? -st_s[NSTEPS].x : st_s[NSTEPS].x;
		yf = st_s[NSTEPS].flip ? -st_s[NSTEPS].y : st_s[NSTEPS].y;
		xr = (xf + CW'(32768)) >>> 16;
		yr = (yf + CW'(32768)) >>> 16;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sc.s <= yr[15:0];
			sc.c <= xr[15:0];
		end
	end

endmodule

[design/euler_to_quaternion_core.sv]
// Request to result: registered through the CORDIC fold, rotation and rounding stages, then product stages A to D.
// Throughput: one request per cycle; the whole pipe advances unless the
// output holds a result that is stalled, so no request is lost or repeated.
// Reset: arst_n (asynchronous, active low) clears all valid bits; payload
// registers are not reset.
module euler_to_quaternion_core
	import e2q_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);

	// CORDIC: fold stage + NSTEPS rotations + rounding; then four product stages
	localparam int LAT = NSTEPS + 6;

	logic adv;
	logic [LAT-1:0] vld_q;

	// Pipe advances when the last stage is empty or being taken
	assign adv = !vld_q[LAT-1] || !out_stall;
	assign in_stall = !adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	sincos_t sc_y, sc_x, sc_z;
	e2q_cordic u_cy (.clk(clk), .adv(adv), .angle(angle_y), .sc(sc_y));
	e2q_cordic u_cx (.clk(clk), .adv(adv), .angle(angle_x), .sc(sc_x));
	e2q_cordic u_cz (.clk(clk), .adv(adv), .angle(angle_z), .sc(sc_z));

	// Stage A: pair products (Q2.28)
	logic signed [31:0] s1s2_s1, s1c2_s1, c1s2_s1, c1c2_s1;
	logic signed [15:0] s3_s1, c3_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			s1s2_s1 <= sc_y.s * sc_x.s;
			s1c2_s1 <= sc_y.s * sc_x.c;
			c1s2_s1 <= sc_y.c * sc_x.s;
			c1c2_s1 <= sc_y.c * sc_x.c;
			s3_s1 <= sc_z.s;
			c3_s1 <= sc_z.c;
		end
	end

	// Stage B: triple products (Q3.42)
	logic signed [47:0] p_s2 [0:7];
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2[0] <= s1s2_s1 * c3_s1;
			p_s2[1] <= c1c2_s1 * s3_s1;
			p_s2[2] <= s1c2_s1 * c3_s1;
			p_s2[3] <= c1s2_s1 * s3_s1;
			p_s2[4] <= c1s2_s1 * c3_s1;
			p_s2[5] <= s1c2_s1 * s3_s1;
			p_s2[6] <= c1c2_s1 * c3_s1;
			p_s2[7] <= s1s2_s1 * s3_s1;
		end
	end

	// Stage C: round each to Q5.14
	logic signed [19:0] r_s3 [0:7];
	for (genvar k = 0; k < 8; k++) begin : g_rnd
		logic signed [47:0] t;
		assign t = (p_s2[k] + 48'sd134217728) >>> 28;
		always_ff @(posedge clk) begin
			if (adv) r_s3[k] <= t[19:0];
		end
	end

	// Stage D: combine and saturate
	function automatic logic signed [15:0] sat(input logic signed [20:0] v);
		begin
			if (v > 21'sd16384) return 16'sd16384;
			if (v < -21'sd16384) return -16'sd16384;
			return v[15:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			quat_x <= sat(21'(r_s3[0]) + 21'(r_s3[1]));
			quat_y <= sat(21'(r_s3[2]) + 21'(r_s3[3]));
			quat_z <= sat(21'(r_s3[4]) - 21'(r_s3[5]));
			quat_w <= sat(21'(r_s3[6]) - 21'(r_s3[7]));
		end
	end

endmodule

[design/e2q_checker.sv]
// Port-level checker for the Euler-to-quaternion core, with its bind.
module e2q_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] quat_x,
	input logic signed [15:0] quat_y,
	input logic signed [15:0] quat_z,
	input logic signed [15:0] quat_w
);

	// Input side stalls only while output holds a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

	// The x and w results lie within unit range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quat_x <= 16'sd16384 && quat_x >= -16'sd16384 &&
			quat_w <= 16'sd16384 && quat_w >= -16'sd16384))
		else $error("quaternion component out of range");

	// A stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(quat_x) &&
			$stable(quat_y) && $stable(quat_z) && $stable(quat_w)))
		else $error("stalled result changed");

	// No result straight out of reset
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid after reset");

endmodule

bind euler_to_quaternion_core e2q_checker u_e2q_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .quat_x(quat_x),
	.quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
);
